FILE: rtl/dchs_pkg.sv
package dchs_pkg;

  // Field widths
  localparam int unsigned BLK_W  = 32;
  localparam int unsigned CNT_W  = 7;
  localparam int unsigned CYL_W  = 10;
  localparam int unsigned HEAD_W = 8;
  localparam int unsigned SEC_W  = 6;
  localparam int unsigned CFG_IDX_W = 2;

  // Divider width: covers the largest divisor, cylinder count 1024
  localparam int unsigned DIV_W  = 11;
  localparam int unsigned STEP_W = 5;
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(BLK_W - 1);

  localparam logic [CNT_W-1:0] CHUNK_SECTORS = 7'd16;
  localparam logic [CNT_W-1:0] MAX_REQUEST   = 7'd64;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHUNK,
    ST_DIV,
    ST_DONE,
    ST_FIN,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_SECTOR,
    PH_HEAD,
    PH_CYL
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_USE_LBA  = 2'd0,
    REG_SPT      = 2'd1,
    REG_MAX_HEAD = 2'd2,
    REG_MAX_CYL  = 2'd3
  } cfg_reg_t;

endpackage

FILE: rtl/dchs_req_if.sv
interface dchs_req_if;
  import dchs_pkg::*;

  logic             valid;
  logic             ready;
  logic [BLK_W-1:0] start_block;
  logic [CNT_W-1:0] sector_count;

  modport source (output valid, output start_block, output sector_count, input ready);
  modport sink   (input valid, input start_block, input sector_count, output ready);
endinterface

FILE: rtl/dchs_cmd_if.sv
interface dchs_cmd_if;
  import dchs_pkg::*;

  logic              valid;
  logic              ready;
  logic [BLK_W-1:0]  block_address;
  logic [CYL_W-1:0]  cylinder;
  logic [HEAD_W-1:0] head;
  logic [SEC_W-1:0]  sector;
  logic [CNT_W-1:0]  chunk_length;
  logic              last;

  modport source (output valid, output block_address, output cylinder, output head,
                  output sector, output chunk_length, output last, input ready);
  modport sink   (input valid, input block_address, input cylinder, input head,
                  input sector, input chunk_length, input last, output ready);
endinterface

FILE: rtl/disk_request_chs_splitter.sv
// Disk request splitter with LBA to CHS conversion.
//
// in_req takes one read request (start_block, sector_count); out_cmd gives
// one transfer command per chunk of at most CHUNK_SECTORS sectors, the last
// one flagged. A count of zero yields no command; counts above 64 act as 64.
// In CHS mode each chunk start is split into sector, head and cylinder by
// one shared restoring divider (one quotient bit per cycle), run three times
// per chunk, and a chunk stops at the track end. Each chunk passes setup,
// three divisions (CHS mode only), length and output states; LBA mode
// skips the divisions.
// in_req.ready is high only while no request is in work.
// Each command waits in the output registers while out_cmd.ready is low;
// the sequencer holds and no later chunk is computed until the transfer.
// Reset (rst_n low, synchronous) returns to idle and loads the geometry
// defaults: CHS mode, 63 sectors per track, max head 15, max cylinder 1023.
// The cfg port writes one register per cycle by index; write only when idle.
module disk_request_chs_splitter (
  input  logic                           clk,
  input  logic                           rst_n,
  dchs_req_if.sink                       in_req,
  dchs_cmd_if.source                     out_cmd,
  input  logic                           cfg_we,
  input  logic [dchs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [dchs_pkg::CYL_W-1:0]     cfg_data
);
  import dchs_pkg::*;

  state_t state_r, state_nxt;
  phase_t phase_r, phase_nxt;

  logic              use_lba_r;
  logic [SEC_W-1:0]  spt_r;
  logic [HEAD_W-1:0] max_head_r;
  logic [CYL_W-1:0]  max_cyl_r;

  logic [BLK_W-1:0]  blk_r, blk_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic [SEC_W-1:0]  room_r, room_nxt;
  logic [SEC_W-1:0]  sec_r, sec_nxt;
  logic [HEAD_W-1:0] head_r, head_nxt;
  logic [CYL_W-1:0]  cyl_r, cyl_nxt;

  logic [BLK_W-1:0]  div_q_r, div_q_nxt;
  logic [DIV_W-1:0]  div_rem_r, div_rem_nxt;
  logic [DIV_W-1:0]  div_d_r, div_d_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;

  logic              in_xfer, out_xfer, last_chunk;
  logic [SEC_W-1:0]  spt_eff;
  logic [DIV_W-1:0]  heads, cyls;
  logic [DIV_W:0]    shifted;
  logic              fits;
  logic [DIV_W-1:0]  rem_step;
  logic [CNT_W-1:0]  len_cap;
  logic [CNT_W-1:0]  count_sat;

  // Handshakes
  assign in_req.ready = (state_r == ST_IDLE);
  assign out_cmd.valid = (state_r == ST_OUT);
  assign in_xfer  = in_req.valid && in_req.ready;
  assign out_xfer = out_cmd.valid && out_cmd.ready;
  assign last_chunk = (left_r == len_r);

  // Drive the command from held registers
  assign out_cmd.block_address = blk_r;
  assign out_cmd.cylinder      = cyl_r;
  assign out_cmd.head          = head_r;
  assign out_cmd.sector        = sec_r;
  assign out_cmd.chunk_length  = len_r;
  assign out_cmd.last          = last_chunk;

  // Geometry as divisors
  assign spt_eff = (spt_r == '0) ? SEC_W'(1) : spt_r;
  assign heads   = DIV_W'(max_head_r) + DIV_W'(1);
  assign cyls    = DIV_W'(max_cyl_r) + DIV_W'(1);

  // Shared divider step: shift in the next dividend bit, subtract if it fits
  assign shifted  = {div_rem_r, div_q_r[BLK_W-1]};
  assign fits     = (shifted >= {1'b0, div_d_r});
  assign rem_step = fits ? DIV_W'(shifted - {1'b0, div_d_r}) : shifted[DIV_W-1:0];

  // Chunk length before the track limit
  assign count_sat = (in_req.sector_count > MAX_REQUEST) ? MAX_REQUEST : in_req.sector_count;
  assign len_cap   = (left_r < CHUNK_SECTORS) ? left_r : CHUNK_SECTORS;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      use_lba_r  <= 1'b0;
      spt_r      <= 6'd63;
      max_head_r <= 8'd15;
      max_cyl_r  <= 10'd1023;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_USE_LBA:  use_lba_r  <= cfg_data[0];
        REG_SPT:      spt_r      <= cfg_data[SEC_W-1:0];
        REG_MAX_HEAD: max_head_r <= cfg_data[HEAD_W-1:0];
        REG_MAX_CYL:  max_cyl_r  <= cfg_data;
      endcase
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (in_xfer && count_sat != '0) state_nxt = ST_CHUNK;
      ST_CHUNK: state_nxt = use_lba_r ? ST_FIN : ST_DIV;
      ST_DIV:   if (step_r == LAST_STEP) state_nxt = ST_DONE;
      ST_DONE:  state_nxt = (phase_r == PH_CYL) ? ST_FIN : ST_DIV;
      ST_FIN:   state_nxt = ST_OUT;
      ST_OUT:   if (out_xfer) state_nxt = last_chunk ? ST_IDLE : ST_CHUNK;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer datapath
  always_comb begin
    phase_nxt   = phase_r;
    blk_nxt     = blk_r;
    left_nxt    = left_r;
    len_nxt     = len_r;
    room_nxt    = room_r;
    sec_nxt     = sec_r;
    head_nxt    = head_r;
    cyl_nxt     = cyl_r;
    div_q_nxt   = div_q_r;
    div_rem_nxt = div_rem_r;
    div_d_nxt   = div_d_r;
    step_nxt    = step_r;
    unique case (state_r)
      ST_IDLE: begin
        blk_nxt  = in_req.start_block;
        left_nxt = count_sat;
      end
      ST_CHUNK: begin
        // Start with the sector division, or zero the fields in LBA mode
        sec_nxt     = '0;
        head_nxt    = '0;
        cyl_nxt     = '0;
        phase_nxt   = PH_SECTOR;
        div_q_nxt   = blk_r;
        div_rem_nxt = '0;
        div_d_nxt   = DIV_W'(spt_eff);
        step_nxt    = '0;
      end
      ST_DIV: begin
        div_q_nxt   = {div_q_r[BLK_W-2:0], fits};
        div_rem_nxt = rem_step;
        step_nxt    = step_r + STEP_W'(1);
      end
      ST_DONE: begin
        // Keep the remainder, feed the quotient to the next division
        div_q_nxt   = div_q_r;
        div_rem_nxt = '0;
        step_nxt    = '0;
        unique case (phase_r)
          PH_SECTOR: begin
            sec_nxt   = div_rem_r[SEC_W-1:0] + SEC_W'(1);
            room_nxt  = spt_eff - div_rem_r[SEC_W-1:0];
            div_d_nxt = heads;
            phase_nxt = PH_HEAD;
          end
          PH_HEAD: begin
            head_nxt  = div_rem_r[HEAD_W-1:0];
            div_d_nxt = cyls;
            phase_nxt = PH_CYL;
          end
          PH_CYL: begin
            cyl_nxt = div_rem_r[CYL_W-1:0];
          end
          default: ;
        endcase
      end
      ST_FIN: begin
        // Stop the chunk at the track end in CHS mode
        if (!use_lba_r && len_cap > CNT_W'(room_r)) len_nxt = CNT_W'(room_r);
        else len_nxt = len_cap;
      end
      ST_OUT: begin
        if (out_xfer) begin
          left_nxt = left_r - len_r;
          blk_nxt  = blk_r + BLK_W'(len_r);
        end
      end
      default: ;
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      phase_r <= PH_SECTOR;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
      step_r  <= step_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    blk_r     <= blk_nxt;
    left_r    <= left_nxt;
    len_r     <= len_nxt;
    room_r    <= room_nxt;
    sec_r     <= sec_nxt;
    head_r    <= head_nxt;
    cyl_r     <= cyl_nxt;
    div_q_r   <= div_q_nxt;
    div_rem_r <= div_rem_nxt;
    div_d_r   <= div_d_nxt;
  end

endmodule
